// ===== src/i2p_pkg.sv =====
package i2p_pkg;

  // Characters with a role in the conversion
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // Error codes carried with a result
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  // Operation applied to every cell of the stack chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_t;

  // Operator precedence: +- 1, */ 2, ^ 3, anything else 0
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    else if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  // ASCII letter or digit
  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

// ===== src/i2p_cell.sv =====
module i2p_cell (
  input  logic              clk,
  input  i2p_pkg::cell_op_t op,
  input  logic [7:0]        up_data,
  input  logic [7:0]        down_data,
  output logic [7:0]        data
);

  // Shift toward the bottom on push, toward the top on pop
  always_ff @(posedge clk) begin
    case (op)
      i2p_pkg::CELL_PUSH: data <= up_data;
      i2p_pkg::CELL_POP:  data <= down_data;
      default:            data <= data;
    endcase
  end

endmodule

// ===== src/infix_to_postfix_converter_unit.sv =====
// Shunting-yard infix to postfix converter. Send one expression character per
// request on the slave side, with tlast on the final one; postfix characters
// come out on the master side with tuser[0] set, and tlast marks the final
// result of an expression or an error result (tuser[2:1] = 1 overflow,
// 2 unmatched ')'), after which the next request starts a fresh expression.
// The operator stack is a chain of STACK_DEPTH cells that shift one place per
// cycle, so the controller handles one request at a time: each request is
// accepted in ST_IDLE and worked in ST_WORK, where each operator popped from
// the chain takes a step of its own; a closing parenthesis drops its '(' in
// the step itself. After the final character every entry still stacked is
// drained, or a bare end result is sent when a closing parenthesis leaves the
// stack empty. Stalls on the master side hold back each step that sends a
// result while the last one waits to be taken.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast,   // end_of_expr
  output logic [2:0] m_tuser    // [0] has_char, [2:1] error
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  i2p_pkg::state_t   state, state_next;
  i2p_pkg::cell_op_t cell_op;
  logic [CW-1:0]     count, count_next;
  logic [7:0]        ch_r;
  logic              last_r;
  logic              flushing, flushing_next;
  logic              any_out, any_out_next;
  logic [7:0]        stack_data [STACK_DEPTH];

  logic              emit;
  logic [7:0]        emit_char;
  logic              emit_has;
  logic              emit_end;
  i2p_pkg::err_t     emit_err;
  logic              out_free;
  logic [7:0]        top;
  logic [7:0]        second;
  logic              full;
  logic              empty;

  // Stack as a chain of cells, top at index 0
  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [7:0] up_d;
      logic [7:0] down_d;
      if (gi == 0) begin : g_first
        assign up_d = ch_r;
      end else begin : g_mid
        assign up_d = stack_data[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_lastc
        assign down_d = 8'd0;
      end else begin : g_inner
        assign down_d = stack_data[gi+1];
      end
      i2p_cell u_cell (
        .clk       (clk),
        .op        (cell_op),
        .up_data   (up_d),
        .down_data (down_d),
        .data      (stack_data[gi])
      );
    end
  endgenerate

  assign top      = stack_data[0];
  assign second   = stack_data[1];
  assign full     = (count == CW'(STACK_DEPTH));
  assign empty    = (count == '0);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == i2p_pkg::ST_IDLE);

  // Hold state, count and the request in progress
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= i2p_pkg::ST_IDLE;
      count    <= '0;
      flushing <= 1'b0;
      any_out  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      flushing <= flushing_next;
      any_out  <= any_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ch_r   <= s_tdata;
      last_r <= s_tlast;
    end
  end

  // One stack step per cycle, unless a step that sends a result waits for the output to be free
  always_comb begin
    state_next    = state;
    count_next    = count;
    flushing_next = flushing;
    any_out_next  = any_out;
    cell_op       = i2p_pkg::CELL_HOLD;
    emit          = 1'b0;
    emit_char     = 8'd0;
    emit_has      = 1'b0;
    emit_end      = 1'b0;
    emit_err      = i2p_pkg::ERR_NONE;

    unique case (state)
      i2p_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next    = i2p_pkg::ST_WORK;
          flushing_next = 1'b0;
          any_out_next  = 1'b0;
        end
      end

      i2p_pkg::ST_WORK: begin
        if (flushing) begin
          // Drain the stack at the end of an expression
          if (!empty) begin
            if (out_free) begin
              emit       = 1'b1;
              emit_char  = top;
              emit_has   = 1'b1;
              emit_end   = (count == CW'(1));
              cell_op    = i2p_pkg::CELL_POP;
              count_next = count - CW'(1);
              if (count == CW'(1)) state_next = i2p_pkg::ST_IDLE;
            end
          end else if (!any_out) begin
            if (out_free) begin
              emit       = 1'b1;
              emit_end   = 1'b1;
              state_next = i2p_pkg::ST_IDLE;
            end
          end else begin
            state_next = i2p_pkg::ST_IDLE;
          end
        end else if (i2p_pkg::is_alnum(ch_r)) begin
          // Operand: pass through
          if (out_free) begin
            emit      = 1'b1;
            emit_char = ch_r;
            emit_has  = 1'b1;
            emit_end  = last_r && empty;
            if (last_r && !empty) flushing_next = 1'b1;
            else state_next = i2p_pkg::ST_IDLE;
          end
        end else if (ch_r == i2p_pkg::CH_RPAREN) begin
          if (!empty && top != i2p_pkg::CH_LPAREN) begin
            // Pop down to the matching parenthesis
            if (out_free) begin
              emit       = 1'b1;
              emit_char  = top;
              emit_has   = 1'b1;
              emit_end   = last_r && (count == CW'(2)) && (second == i2p_pkg::CH_LPAREN);
              cell_op    = i2p_pkg::CELL_POP;
              count_next = count - CW'(1);
            end
          end else if (empty) begin
            if (out_free) begin
              emit       = 1'b1;
              emit_end   = 1'b1;
              emit_err   = i2p_pkg::ERR_UNMATCHED;
              state_next = i2p_pkg::ST_IDLE;
            end
          end else begin
            // Drop the matching parenthesis
            cell_op    = i2p_pkg::CELL_POP;
            count_next = count - CW'(1);
            if (last_r) flushing_next = 1'b1;
            else state_next = i2p_pkg::ST_IDLE;
          end
        end else if (ch_r != i2p_pkg::CH_LPAREN && !empty &&
                     i2p_pkg::prec_of(ch_r) <= i2p_pkg::prec_of(top)) begin
          // Pop operators that bind at least as tightly
          if (out_free) begin
            emit       = 1'b1;
            emit_char  = top;
            emit_has   = 1'b1;
            cell_op    = i2p_pkg::CELL_POP;
            count_next = count - CW'(1);
          end
        end else if (full) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_end   = 1'b1;
            emit_err   = i2p_pkg::ERR_OVERFLOW;
            count_next = '0;
            state_next = i2p_pkg::ST_IDLE;
          end
        end else begin
          // Push the operator or opening parenthesis
          cell_op    = i2p_pkg::CELL_PUSH;
          count_next = count + CW'(1);
          if (last_r) flushing_next = 1'b1;
          else state_next = i2p_pkg::ST_IDLE;
        end
        if (emit) any_out_next = 1'b1;
      end

      default: state_next = i2p_pkg::ST_IDLE;
    endcase
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_char;
      m_tlast <= emit_end;
      m_tuser <= {emit_err, emit_has};
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:1] != i2p_pkg::ERR_NONE) |-> m_tlast)
    else $error("error result without end mark");

  a_err_no_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tuser[2:1] == i2p_pkg::ERR_NONE))
    else $error("character result carries an error");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result loaded over one not yet taken");

  a_accept_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> (state == i2p_pkg::ST_WORK) && !flushing)
    else $error("accepted request not started");
`endif

endmodule
